/* sv/hsik_pkg.sv */
// Package for the top-H set intersection kernel.
// Holds field widths and shared constants; no dependencies.
package hsik_pkg;

    localparam int IDX_W    = 10;               // list index field
    localparam int CNT_W    = 11;               // counters and top_count
    localparam int FRAC_W   = 16;               // Q1.16 score fraction bits
    localparam int SCORE_W  = 17;               // score field
    localparam int DIVD_W   = CNT_W + FRAC_W;   // dividend of score division
    localparam int S_DATA_W = 16;               // input tdata, whole bytes
    localparam int M_DATA_W = 32;               // output tdata, whole bytes

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [CNT_W-1:0] TOP_RESET = CNT_W'(1);

    localparam logic MODE_REF   = 1'b0;
    localparam logic MODE_PROBE = 1'b1;

endpackage

/* sv/top_h_set_intersection_kernel.sv */
// Top level of the top-H set intersection kernel: control sequencer, counters,
// output register. Depends on hsik_pkg, hsik_mark_mem and hsik_div.
//
//  channel   direction  beat content
//  s_axis    in         tdata: index; tuser: mode, first; tlast: last
//  m_axis    out        tdata: match_count, score
//  cfg       in         data: top_count
//
// A reference item that is not first is marked in the table (if counted) as it is accepted. A
// first reference item clears the table, one entry a cycle, then writes its own mark. A probe
// reads the registered table output in S_PROBE; a last probe then starts the serial divider
// and waits in S_DIV to load the result. Reset runs the same clearing pass and holds
// s_axis_tready low while it runs. A stalled output only holds the block when the next
// result is ready to load.
module top_h_set_intersection_kernel #(
    parameter int TABLE_SIZE = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hsik_pkg::S_DATA_W-1:0] s_axis_tdata,   // [9:0] index
    input  logic [1:0]                    s_axis_tuser,   // [0] mode, [1] first
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hsik_pkg::M_DATA_W-1:0] m_axis_tdata,   // [10:0] match_count,
                                                          // [27:11] score
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hsik_pkg::CNT_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(TABLE_SIZE);

    typedef enum logic [2:0] {
        S_CLEAR, S_REF_WR, S_IDLE, S_PROBE, S_DIV
    } t_state;

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_clr_addr, n_clr_addr;
    logic [hsik_pkg::CNT_W-1:0]  r_top_count;
    logic [hsik_pkg::CNT_W-1:0]  r_ref_seen, n_ref_seen;
    logic [hsik_pkg::CNT_W-1:0]  r_probe_seen, n_probe_seen;
    logic [hsik_pkg::CNT_W-1:0]  r_match, n_match;
    logic                        r_pend_wr, n_pend_wr;
    logic [AW-1:0]               r_pend_addr, n_pend_addr;
    logic                        r_hit_try, n_hit_try;
    logic                        r_last, n_last;
    logic                        r_out_valid, n_out_valid;
    logic [hsik_pkg::M_DATA_W-1:0] r_out_data, n_out_data;

    logic                        w_accept;
    logic                        w_mode;
    logic                        w_first;
    logic [31:0]                 w_idx32;
    logic [AW-1:0]               w_addr;
    logic                        w_in_table;
    logic [hsik_pkg::CNT_W-1:0]  w_seen_base;
    logic                        w_take;
    logic                        w_mem_we;
    logic [AW-1:0]               w_mem_waddr;
    logic                        w_mem_wdata;
    logic                        w_mem_rdata;
    logic                        w_div_start;
    logic [hsik_pkg::DIVD_W-1:0] w_div_dividend;
    logic                        w_div_busy;
    logic [hsik_pkg::DIVD_W-1:0] w_div_quot;
    logic [hsik_pkg::SCORE_W-1:0] w_score;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mode        = s_axis_tuser[0];
    assign w_first       = s_axis_tuser[1];
    assign w_idx32       = 32'(s_axis_tdata[hsik_pkg::IDX_W-1:0]);
    assign w_addr        = w_idx32[AW-1:0];
    assign w_in_table    = (w_idx32 < 32'(TABLE_SIZE));
    assign o_cfg_ready   = 1'b1;

    // Count an item only while its list is inside the first top_count places.
    always_comb begin
        if (w_mode == hsik_pkg::MODE_REF) begin
            w_seen_base = w_first ? '0 : r_ref_seen;
        end else begin
            w_seen_base = w_first ? '0 : r_probe_seen;
        end
        w_take = (w_seen_base < r_top_count) && (w_seen_base != hsik_pkg::CNT_MAX);
    end

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = w_addr;
        w_mem_wdata = 1'b1;
        case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                w_mem_wdata = 1'b0;
            end
            S_REF_WR: begin
                w_mem_we    = r_pend_wr;
                w_mem_waddr = r_pend_addr;
            end
            S_IDLE: begin
                w_mem_we = w_accept && (w_mode == hsik_pkg::MODE_REF) && !w_first
                           && w_take && w_in_table;
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    assign w_score = (r_top_count == '0) ? '0 : w_div_quot[hsik_pkg::SCORE_W-1:0];
    assign w_div_dividend = {n_match, hsik_pkg::FRAC_W'(0)};

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_ref_seen   = r_ref_seen;
        n_probe_seen = r_probe_seen;
        n_match      = r_match;
        n_pend_wr    = r_pend_wr;
        n_pend_addr  = r_pend_addr;
        n_hit_try    = r_hit_try;
        n_last       = r_last;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        w_div_start  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(TABLE_SIZE - 1)) begin
                    n_clr_addr = '0;
                    n_state    = S_REF_WR;
                end
            end
            S_REF_WR: begin
                n_pend_wr = 1'b0;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (w_mode == hsik_pkg::MODE_REF) begin
                        n_ref_seen = w_seen_base + hsik_pkg::CNT_W'(w_take);
                        if (w_first) begin
                            // hold the mark until the table sweep is done
                            n_pend_wr   = w_take && w_in_table;
                            n_pend_addr = w_addr;
                            n_state     = S_CLEAR;
                        end
                    end else begin
                        n_probe_seen = w_seen_base + hsik_pkg::CNT_W'(w_take);
                        if (w_first) begin
                            n_match = '0;
                        end
                        n_hit_try = w_take && w_in_table;
                        n_last    = s_axis_tlast;
                        n_state   = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (r_hit_try && w_mem_rdata && (r_match != hsik_pkg::CNT_MAX)) begin
                    n_match = r_match + hsik_pkg::CNT_W'(1);
                end
                if (r_last) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (!w_div_busy && (!r_out_valid || m_axis_tready)) begin
                    n_out_valid = 1'b1;
                    n_out_data  = hsik_pkg::M_DATA_W'({w_score, r_match});
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_top_count  <= hsik_pkg::TOP_RESET;
            r_ref_seen   <= '0;
            r_probe_seen <= '0;
            r_match      <= '0;
            r_pend_wr    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_ref_seen   <= n_ref_seen;
            r_probe_seen <= n_probe_seen;
            r_match      <= n_match;
            r_pend_wr    <= n_pend_wr;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_top_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_hit_try   <= n_hit_try;
        r_last      <= n_last;
        r_out_data  <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    hsik_mark_mem #(
        .DEPTH (TABLE_SIZE),
        .AW    (AW)
    ) u_mark_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_mem_rdata)
    );

    hsik_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_top_count),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_quot)
    );

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == S_DIV))
        else $error("divider busy outside the divide state");

    a_match_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match <= r_probe_seen)
        else $error("match count exceeds counted probes");

    a_out_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DIV))
        else $error("result loaded outside the divide state");

    a_no_write_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_DIV) |-> !w_mem_we)
        else $error("table written while a probe is in flight");

endmodule

/* sv/hsik_mark_mem.sv */
// One-bit membership table: synchronous memory, one write and one read port.
// Read data is registered. Uses no package items.
module hsik_mark_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/hsik_div.sv */
// Restoring divider, one quotient bit per cycle, for the Q1.16 score.
// Depends on hsik_pkg for the dividend and count widths.
module hsik_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hsik_pkg::DIVD_W-1:0] i_dividend,
    input  logic [hsik_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic [hsik_pkg::DIVD_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(hsik_pkg::DIVD_W);

    logic                        r_busy;
    logic [STEP_W-1:0]           r_step;
    logic [hsik_pkg::DIVD_W-1:0] r_quot;     // dividend shifts out, quotient in
    logic [hsik_pkg::CNT_W-1:0]  r_rem;
    logic [hsik_pkg::CNT_W-1:0]  r_divisor;

    logic [hsik_pkg::CNT_W:0]    w_trial;
    logic                        w_fits;

    assign w_trial = {r_rem, r_quot[hsik_pkg::DIVD_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == STEP_W'(hsik_pkg::DIVD_W - 1)) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            if (w_fits) begin
                r_rem <= hsik_pkg::CNT_W'(w_trial - {1'b0, r_divisor});
            end else begin
                r_rem <= w_trial[hsik_pkg::CNT_W-1:0];
            end
            r_quot <= {r_quot[hsik_pkg::DIVD_W-2:0], w_fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

/* sim/tb.sv */
// Self-checking bench for top_h_set_intersection_kernel: directed list cases, then random
// reference/probe lists under varied stalls. Depends on hsik_pkg and the kernel RTL.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [hsik_pkg::CNT_W-1:0]   match_count;
        logic [hsik_pkg::SCORE_W-1:0] score;
    } t_overlap;

    localparam int SETTLE_CYCLES = 1100;    // table clear plus divide, with margin

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [hsik_pkg::S_DATA_W-1:0]  s_axis_tdata;     // [9:0] index
    logic [1:0]                     s_axis_tuser;     // [0] mode, [1] first
    logic                           s_axis_tlast;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [hsik_pkg::M_DATA_W-1:0]  m_axis_tdata;     // [10:0] match_count, [27:11] score
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [hsik_pkg::CNT_W-1:0]     i_cfg_data;

    // predictor state
    logic [1023:0]                  marked;
    logic [hsik_pkg::CNT_W-1:0]     hits;
    logic [hsik_pkg::CNT_W-1:0]     refs_taken;
    logic [hsik_pkg::CNT_W-1:0]     probes_taken;
    logic [hsik_pkg::CNT_W-1:0]     top_count_q;

    t_overlap                       pending_overlaps[$];
    logic [hsik_pkg::IDX_W-1:0]     ref_indices[$];
    int                             mismatch_count;
    int                             items_sent;
    int                             send_idle_pct;
    int                             recv_idle_pct;

    top_h_set_intersection_kernel u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic predict_overlap(input logic mode, input logic [hsik_pkg::IDX_W-1:0] idx,
                                   input logic first, input logic last);
        logic [hsik_pkg::DIVD_W-1:0] dividend;
        t_overlap                    res;
        if (mode == hsik_pkg::MODE_REF) begin
            if (first) begin
                marked     = '0;
                refs_taken = '0;
            end
            if (refs_taken < top_count_q && refs_taken != hsik_pkg::CNT_MAX) begin
                marked[idx] = 1'b1;
                refs_taken++;
            end
        end else begin
            if (first) begin
                hits         = '0;
                probes_taken = '0;
            end
            if (probes_taken < top_count_q && probes_taken != hsik_pkg::CNT_MAX) begin
                if (marked[idx] && hits != hsik_pkg::CNT_MAX)
                    hits++;
                probes_taken++;
            end
            if (last) begin
                dividend        = {hits, hsik_pkg::FRAC_W'(0)};
                res.match_count = hits;
                res.score       = (top_count_q == '0) ? '0 :
                                  hsik_pkg::SCORE_W'(dividend / top_count_q);
                pending_overlaps.push_back(res);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_overlap want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_overlaps.size() == 0) begin
                report_mismatch("unexpected beat, match_count",
                                int'(m_axis_tdata[hsik_pkg::CNT_W-1:0]), -1);
            end else begin
                want = pending_overlaps.pop_front();
                if (m_axis_tdata[hsik_pkg::CNT_W-1:0] !== want.match_count)
                    report_mismatch("match_count", int'(m_axis_tdata[hsik_pkg::CNT_W-1:0]),
                                    int'(want.match_count));
                if (m_axis_tdata[hsik_pkg::CNT_W +: hsik_pkg::SCORE_W] !== want.score)
                    report_mismatch("score",
                                    int'(m_axis_tdata[hsik_pkg::CNT_W +: hsik_pkg::SCORE_W]),
                                    int'(want.score));
            end
        end
    end

    // Present one beat at the falling edge; return right after it is taken.
    task automatic send_item(input logic mode, input logic [hsik_pkg::IDX_W-1:0] idx,
                             input logic first, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= hsik_pkg::S_DATA_W'(idx);
        s_axis_tuser  <= {first, mode};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_overlap(mode, idx, first, last);
        items_sent++;
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_overlaps.size() != 0)
            @(posedge i_clk);
    endtask

    // Reference lists leave no result behind, so give a clear pass time to finish too.
    task automatic drain();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_top_count(input logic [hsik_pkg::CNT_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        top_count_q = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [hsik_pkg::IDX_W-1:0] pick_index();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45 && ref_indices.size() != 0)
            return ref_indices[$urandom_range(ref_indices.size() - 1)];
        else if (sel < 75)
            return hsik_pkg::IDX_W'($urandom_range(31));
        else
            return hsik_pkg::IDX_W'($urandom_range(1023));
    endfunction

    task automatic send_list(input logic mode, input int len, input logic with_first);
        logic [hsik_pkg::IDX_W-1:0] idx;
        if (mode == hsik_pkg::MODE_REF && with_first)
            ref_indices.delete();
        for (int k = 0; k < len; k++) begin
            idx = pick_index();
            if (mode == hsik_pkg::MODE_REF)
                ref_indices.push_back(idx);
            send_item(mode, idx, with_first && k == 0, k == len - 1);
        end
    endtask

    task automatic test_reset_top_count();
        send_item(hsik_pkg::MODE_PROBE, 10'd5, 1'b1, 1'b1);   // empty table after reset
        send_item(hsik_pkg::MODE_REF,   10'd5, 1'b1, 1'b0);
        send_item(hsik_pkg::MODE_PROBE, 10'd5, 1'b1, 1'b1);   // full score with top_count 1
    endtask

    task automatic test_index_extremes();
        write_top_count(hsik_pkg::CNT_W'(4));
        send_item(hsik_pkg::MODE_REF,   10'd0,    1'b1, 1'b0);
        send_item(hsik_pkg::MODE_REF,   10'd1023, 1'b0, 1'b0);
        send_item(hsik_pkg::MODE_REF,   10'd1023, 1'b0, 1'b0);
        send_item(hsik_pkg::MODE_REF,   10'd512,  1'b0, 1'b1);
        send_item(hsik_pkg::MODE_PROBE, 10'd0,    1'b1, 1'b0);
        send_item(hsik_pkg::MODE_PROBE, 10'd1023, 1'b0, 1'b0);
        send_item(hsik_pkg::MODE_PROBE, 10'd1023, 1'b0, 1'b0);
        send_item(hsik_pkg::MODE_PROBE, 10'd7,    1'b0, 1'b1);
    endtask

    task automatic test_past_top_count();
        write_top_count(hsik_pkg::CNT_W'(2));
        send_item(hsik_pkg::MODE_REF,   10'd10, 1'b1, 1'b0);
        send_item(hsik_pkg::MODE_REF,   10'd11, 1'b0, 1'b0);
        send_item(hsik_pkg::MODE_REF,   10'd12, 1'b0, 1'b1); // dropped, list already full
        send_item(hsik_pkg::MODE_PROBE, 10'd12, 1'b1, 1'b0);
        send_item(hsik_pkg::MODE_PROBE, 10'd10, 1'b0, 1'b0);
        send_item(hsik_pkg::MODE_PROBE, 10'd11, 1'b0, 1'b1); // dropped but still reports
        send_item(hsik_pkg::MODE_PROBE, 10'd10, 1'b0, 1'b1); // no first: counters carry on
    endtask

    task automatic test_top_count_limits();
        write_top_count(hsik_pkg::CNT_W'(0));
        send_item(hsik_pkg::MODE_REF,   10'd3, 1'b1, 1'b1);
        send_item(hsik_pkg::MODE_PROBE, 10'd3, 1'b1, 1'b1);
        write_top_count(hsik_pkg::CNT_MAX);
        send_item(hsik_pkg::MODE_REF,   10'd3, 1'b1, 1'b1);
        send_item(hsik_pkg::MODE_PROBE, 10'd3, 1'b1, 1'b0);
        send_item(hsik_pkg::MODE_PROBE, 10'd3, 1'b0, 1'b1);
        write_top_count(hsik_pkg::CNT_W'(1024));
        send_item(hsik_pkg::MODE_REF,   10'd1000, 1'b1, 1'b0);
        send_item(hsik_pkg::MODE_REF,   10'd1,    1'b0, 1'b1);
        send_item(hsik_pkg::MODE_PROBE, 10'd1,    1'b1, 1'b1);
    endtask

    task automatic test_random_lists(input int s_pct, input int r_pct, input int n_items);
        int seg_end;
        int pick;
        int max_len;
        int top;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int seg = 0; seg < 3; seg++) begin
            top = ($urandom_range(5) == 0) ? 1024 : $urandom_range(1, 24);
            write_top_count(hsik_pkg::CNT_W'(top));
            max_len = (top > 30) ? 40 : top + 3;
            seg_end = items_sent + n_items / 3;
            while (items_sent < seg_end) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_list(hsik_pkg::MODE_REF, $urandom_range(1, max_len), 1'b1);
                    repeat ($urandom_range(1, 2))
                        send_list(hsik_pkg::MODE_PROBE, $urandom_range(1, max_len), 1'b1);
                end else if (pick < 85) begin
                    send_list(hsik_pkg::MODE_PROBE, $urandom_range(1, max_len), 1'b0);
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_item(1'($urandom_range(1)),
                                  hsik_pkg::IDX_W'($urandom_range(1023)),
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                // now and then, hold the stream until every result is back
                if ($urandom_range(39) == 0)
                    wait_results_done();
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        s_axis_tlast   = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        marked         = '0;
        hits           = '0;
        refs_taken     = '0;
        probes_taken   = '0;
        top_count_q    = hsik_pkg::TOP_RESET;
        mismatch_count = 0;
        items_sent     = 0;
        send_idle_pct  = 19;
        recv_idle_pct  = 55;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_top_count();
        test_index_extremes();
        test_past_top_count();
        test_top_count_limits();
        test_random_lists(19, 55, 420);
        test_random_lists(55, 19, 420);
        test_random_lists(0, 0, 420);

        drain();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
sv/hsik_pkg.sv
sv/hsik_mark_mem.sv
sv/hsik_div.sv
sv/top_h_set_intersection_kernel.sv
sim/tb.sv
